FILE: src/rif_pkg.sv
package rif_pkg;

  // Field widths.
  localparam int ValueW    = 32;
  localparam int RadixW    = 5;
  localparam int AlphaW    = 64;
  localparam int CharW     = 8;
  localparam int AlphaSlot = 16;
  localparam int MaxDigits = 32;
  localparam int DigCntW   = 6;

  // Special characters.
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;

  // Configuration register indexes.
  localparam logic [1:0] CfgRadixLength = 2'd0;
  localparam logic [1:0] CfgAlphaLow    = 2'd1;
  localparam logic [1:0] CfgAlphaHigh   = 2'd2;

  // Configuration reset values.
  localparam logic [RadixW-1:0] RadixReset   = 5'd10;
  localparam logic [AlphaW-1:0] AlphaLoReset = 64'h3736_3534_3332_3130;
  localparam logic [AlphaW-1:0] AlphaHiReset = 64'h0000_0000_0000_3938;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [RadixW-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] quotient;
    logic [RadixW-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: src/rif_alpha_check.sv
module rif_alpha_check #(
  parameter int MaxRadix = 16
) (
  input  logic [rif_pkg::RadixW-1:0]   len_i,
  input  logic [2*rif_pkg::AlphaW-1:0] alpha_i,
  output logic                         ok_o
);

  logic bad_char;
  logic dup_char;

  // Scan the used characters for forbidden bytes and pairwise duplicates.
  always_comb begin
    bad_char = 1'b0;
    dup_char = 1'b0;
    for (int i = 0; i < rif_pkg::AlphaSlot; i++) begin
      if (rif_pkg::RadixW'(i) < len_i) begin
        if (alpha_i[8*i +: 8] == 8'h00 || alpha_i[8*i +: 8] == rif_pkg::CharPlus ||
            alpha_i[8*i +: 8] == rif_pkg::CharMinus) begin
          bad_char = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (alpha_i[8*i +: 8] == alpha_i[8*j +: 8]) begin
            dup_char = 1'b1;
          end
        end
      end
    end
  end

  // The radix must lie between two and the largest supported radix.
  assign ok_o = (len_i >= rif_pkg::RadixW'(2)) && (len_i <= rif_pkg::RadixW'(MaxRadix)) &&
                !bad_char && !dup_char;

endmodule

FILE: src/rif_divider.sv
module rif_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rif_pkg::div_req_t req_i,
  output rif_pkg::div_rsp_t rsp_o
);

  localparam int CntW = $clog2(rif_pkg::ValueW);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [rif_pkg::ValueW-1:0]   quo_q, quo_d;
  logic [rif_pkg::RadixW-1:0]   rem_q, rem_d;
  logic [rif_pkg::RadixW-1:0]   div_q, div_d;
  logic [rif_pkg::RadixW-1:0]   shifted;
  logic                         fits;

  // One restoring division step: bring in the next dividend bit and try to subtract.
  assign shifted = {rem_q[rif_pkg::RadixW-2:0], quo_q[rif_pkg::ValueW-1]};
  assign fits    = shifted >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[rif_pkg::ValueW-2:0], fits};
      rem_d = fits ? (shifted - div_q) : shifted;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(rif_pkg::ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

`ifndef SYNTH
  // A finished division leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");
  // A new division is never launched over a running one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");
  // The last step is followed by the done pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (busy_q && !req_i.start && cnt_q == CntW'(rif_pkg::ValueW - 1)) |=> done_q)
    else $error("divider missed its done pulse");
`endif

endmodule

FILE: src/radix_integer_formatter.sv
// Channel  | Direction | Handshake            | Payload
// config   | in        | cfg_we_i             | cfg_index_i, cfg_data_i
// value    | in        | start && !busy       | value_i
// result   | out       | out_valid_o          | character_o, last_o
//
// Each digit takes one division in the shared bit-serial divider, so busy stays high
// longer the more digits a value has, and longer still with a minus sign
// (longest for the most negative value in radix 2).
// The result stream of one item is one character per cycle and cannot be stalled.
// An invalid alphabet accepts the value and produces no characters.
// Reset restores radix 10 with the alphabet of decimal digits.
module radix_integer_formatter #(
  parameter int MAX_RADIX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic signed [rif_pkg::ValueW-1:0] value_i,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [rif_pkg::AlphaW-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  output logic [rif_pkg::CharW-1:0]     character_o,
  output logic                          last_o
);

  localparam int DigitW = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int PtrW   = $clog2(rif_pkg::MaxDigits);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [rif_pkg::RadixW-1:0]      radix_len_q;
  logic [rif_pkg::AlphaW-1:0]      alpha_lo_q, alpha_hi_q;
  logic [2*rif_pkg::AlphaW-1:0]    alpha;
  logic                            alpha_ok;
  logic                            neg_q, neg_d;
  logic                            sign_pend_q, sign_pend_d;
  logic [rif_pkg::DigCntW-1:0]     nd_q, nd_d;
  logic [PtrW-1:0]                 ptr_q, ptr_d;
  logic [DigitW-1:0]               digits_q [rif_pkg::MaxDigits];
  logic                            dig_we;
  logic [DigitW-1:0]               cur_digit;
  logic [rif_pkg::ValueW-1:0]      raw, mag_in;
  logic                            out_valid_q, out_valid_d;
  logic [rif_pkg::CharW-1:0]       char_q, char_d;
  logic                            last_q, last_d;
  rif_pkg::div_req_t               div_req;
  rif_pkg::div_rsp_t               div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_len_q <= rif_pkg::RadixReset;
      alpha_lo_q  <= rif_pkg::AlphaLoReset;
      alpha_hi_q  <= rif_pkg::AlphaHiReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rif_pkg::CfgRadixLength: radix_len_q <= cfg_data_i[rif_pkg::RadixW-1:0];
        rif_pkg::CfgAlphaLow:    alpha_lo_q  <= cfg_data_i;
        rif_pkg::CfgAlphaHigh:   alpha_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alpha = {alpha_hi_q, alpha_lo_q};

  rif_alpha_check #(
    .MaxRadix(MAX_RADIX)
  ) u_check (
    .len_i  (radix_len_q),
    .alpha_i(alpha),
    .ok_o   (alpha_ok)
  );

  rif_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Magnitude of the input; the most negative value maps to 2^31 unchanged.
  assign raw       = value_i;
  assign mag_in    = raw[rif_pkg::ValueW-1] ? (~raw + rif_pkg::ValueW'(1)) : raw;
  assign cur_digit = digits_q[ptr_q];

  // Sequencer: divide repeatedly for the digits, then emit sign and digits.
  always_comb begin
    state_d          = state_q;
    neg_d            = neg_q;
    sign_pend_d      = sign_pend_q;
    nd_d             = nd_q;
    ptr_d            = ptr_q;
    dig_we           = 1'b0;
    out_valid_d      = 1'b0;
    char_d           = char_q;
    last_d           = last_q;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_len_q;
    unique case (state_q)
      StIdle: begin
        if (start && alpha_ok) begin
          neg_d            = raw[rif_pkg::ValueW-1];
          nd_d             = '0;
          div_req.start    = 1'b1;
          div_req.dividend = mag_in;
          state_d          = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          dig_we = 1'b1;
          nd_d   = nd_q + rif_pkg::DigCntW'(1);
          if (div_rsp.quotient == '0 ||
              nd_q == rif_pkg::DigCntW'(rif_pkg::MaxDigits - 1)) begin
            ptr_d       = nd_q[PtrW-1:0];
            sign_pend_d = neg_q;
            state_d     = StEmit;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      StEmit: begin
        out_valid_d = 1'b1;
        if (sign_pend_q) begin
          char_d      = rif_pkg::CharMinus;
          last_d      = 1'b0;
          sign_pend_d = 1'b0;
        end else begin
          char_d = alpha[8*int'(cur_digit) +: 8];
          last_d = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = StIdle;
          end else begin
            ptr_d = ptr_q - PtrW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_q       <= 1'b0;
      sign_pend_q <= 1'b0;
      nd_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      sign_pend_q <= sign_pend_d;
      nd_q        <= nd_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Digit buffer and output payload.
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[nd_q[PtrW-1:0]] <= div_rsp.remainder[DigitW-1:0];
    end
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy        = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // An invalid alphabet never makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && !alpha_ok) |=> !busy)
    else $error("busy after a value with an invalid alphabet");
  // The closing character is always a digit, never the sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && last_o) |-> (character_o != rif_pkg::CharMinus))
    else $error("sign emitted as the last character");
  // The digit count never exceeds the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      nd_q <= rif_pkg::DigCntW'(rif_pkg::MaxDigits))
    else $error("digit count overflow");
`endif

endmodule
